/* hw/rtl/txcon_pkg.sv */
// ----------------------------------------------------------------------------
// txcon_pkg
// Shared constants, codes and types of the text console cursor engine.
// ----------------------------------------------------------------------------
package txcon_pkg;

    // Default grid geometry
    localparam int MAX_ROWS_DEF = 32;
    localparam int MAX_COLS_DEF = 128;

    // Port widths
    localparam int CMD_W      = 2;
    localparam int CHAR_W     = 8;
    localparam int ATTR_W     = 8;
    localparam int COLOR_W    = 4;
    localparam int COLS_CFG_W = 8;
    localparam int ROWS_CFG_W = 6;
    localparam int OUT_ROW_W  = 5;
    localparam int OUT_COL_W  = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Commands
    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FG_COLOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS     = 2'd3;

    // Configuration reset values
    localparam logic [COLOR_W-1:0]    FG_RESET   = 4'd7;
    localparam logic [COLOR_W-1:0]    BG_RESET   = 4'd0;
    localparam logic [COLS_CFG_W-1:0] COLS_RESET = 8'd80;
    localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = 6'd25;

    // Control characters
    localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    // Fill attributes and tab stop
    localparam logic [ATTR_W-1:0] ATTR_SCROLL_FILL = 8'h07;
    localparam logic [ATTR_W-1:0] ATTR_CLEAR       = 8'h00;
    localparam int                TAB_STEP         = 8;

    typedef struct packed {
        logic [COLOR_W-1:0]    fg_color;
        logic [COLOR_W-1:0]    back_color;
        logic [COLS_CFG_W-1:0] cols_in_use;
        logic [ROWS_CFG_W-1:0] rows_in_use;
    } txcon_cfg_t;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic [ATTR_W-1:0] attr;
    } txcon_cell_t;

    typedef struct packed {
        logic                 cell_written;
        logic [OUT_ROW_W-1:0] written_row;
        logic [OUT_COL_W-1:0] written_col;
        logic [CHAR_W-1:0]    written_char;
        logic [ATTR_W-1:0]    written_attr;
        logic                 did_scroll;
        logic [OUT_COL_W-1:0] cursor_col;
        logic [OUT_ROW_W-1:0] cursor_row;
        logic [CHAR_W-1:0]    cell_char;
        logic [ATTR_W-1:0]    cell_attr;
    } txcon_result_t;

endpackage

/* hw/rtl/txcon_grid_mem.sv */
// ----------------------------------------------------------------------------
// txcon_grid_mem
// Cell store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module txcon_grid_mem
    import txcon_pkg::*;
#(
    parameter int   DEPTH = MAX_ROWS_DEF * MAX_COLS_DEF,
    localparam int  AW    = $clog2(DEPTH)
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  txcon_cell_t   wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output txcon_cell_t   rdata
);

    txcon_cell_t mem [DEPTH];
    txcon_cell_t rdata_reg;

    // Write, and read with old data on a same-address collision
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/txcon_seq.sv */
// ----------------------------------------------------------------------------
// txcon_seq
// Command sequencer: cursor update, cell stores, read, scroll and clear
// walks over the cell store, and the result register.
// ----------------------------------------------------------------------------
module txcon_seq
    import txcon_pkg::*;
#(
    parameter int  MAX_ROWS = MAX_ROWS_DEF,
    parameter int  MAX_COLS = MAX_COLS_DEF,
    localparam int AW       = $clog2(MAX_ROWS * MAX_COLS)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  txcon_cfg_t        cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [CMD_W-1:0]  cmd,
    input  logic [CHAR_W-1:0] char_byte,
    input  logic [4:0]        read_row,
    input  logic [6:0]        read_col,
    output logic              out_valid,
    input  logic              out_ready,
    output txcon_result_t     res,
    output logic              mem_we,
    output logic [AW-1:0]     mem_waddr,
    output txcon_cell_t       mem_wdata,
    output logic              mem_re,
    output logic [AW-1:0]     mem_raddr,
    input  txcon_cell_t       mem_rdata
);

    localparam int CW     = $clog2(MAX_COLS);
    localparam int RW     = $clog2(MAX_ROWS);
    localparam int CELLS  = MAX_ROWS * MAX_COLS;
    localparam int CMP_W  = (CW + 1 > COLS_CFG_W) ? CW + 1 : COLS_CFG_W;
    localparam int RCMP_W = (RW + 1 > ROWS_CFG_W) ? RW + 1 : ROWS_CFG_W;

    localparam logic [AW-1:0] ROW_STRIDE  = AW'(MAX_COLS);
    localparam logic [AW-1:0] SCROLL_LAST = AW'(CELLS - MAX_COLS - 1);
    localparam logic [AW-1:0] FILL_FIRST  = AW'(CELLS - MAX_COLS);
    localparam logic [AW-1:0] CELL_LAST   = AW'(CELLS - 1);

    localparam logic [2:0] ST_INIT   = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_RD     = 3'd2;
    localparam logic [2:0] ST_SCROLL = 3'd3;
    localparam logic [2:0] ST_DRAIN  = 3'd4;
    localparam logic [2:0] ST_FILL   = 3'd5;
    localparam logic [2:0] ST_CLEAR  = 3'd6;
    localparam logic [2:0] ST_EMIT   = 3'd7;

    logic [2:0]    state_reg,    state_next;
    logic [AW-1:0] scan_reg,     scan_next;
    logic          wr_pend_reg,  wr_pend_next;
    logic [AW-1:0] wr_addr_reg,  wr_addr_next;
    logic [CW-1:0] cur_col_reg,  cur_col_next;
    logic [RW-1:0] cur_row_reg,  cur_row_next;
    logic          rd_ok_reg,    rd_ok_next;
    txcon_result_t stage_reg,    stage_next;
    txcon_result_t out_reg;
    logic          out_valid_reg, out_valid_next;
    logic          out_load;

    // Effective limits
    logic [CMP_W-1:0]  cols_cfg, eff_cols;
    logic [RCMP_W-1:0] rows_cfg, eff_rows;

    assign cols_cfg = CMP_W'(cfg.cols_in_use);
    assign rows_cfg = RCMP_W'(cfg.rows_in_use);
    assign eff_cols = (cols_cfg == '0) ? CMP_W'(1) :
                      (cols_cfg > CMP_W'(MAX_COLS)) ? CMP_W'(MAX_COLS) : cols_cfg;
    assign eff_rows = (rows_cfg == '0) ? RCMP_W'(1) :
                      (rows_cfg > RCMP_W'(MAX_ROWS)) ? RCMP_W'(MAX_ROWS) : rows_cfg;

    // Put decode: next cursor, stored cell, scroll
    logic [CMP_W-1:0]  col_ext, tab_col, inc_col;
    logic [RCMP_W-1:0] row_inc;
    logic [CW-1:0]     put_col;
    logic [RW-1:0]     put_row;
    logic              go_nl, put_scroll, st_en;
    logic [CW-1:0]     st_col;
    logic [CHAR_W-1:0] st_char;
    logic [AW-1:0]     st_addr;
    logic [ATTR_W-1:0] cur_attr;

    assign col_ext  = CMP_W'(cur_col_reg);
    assign tab_col  = (col_ext + CMP_W'(TAB_STEP)) & ~CMP_W'(TAB_STEP - 1);
    assign inc_col  = col_ext + CMP_W'(1);
    assign row_inc  = RCMP_W'(cur_row_reg) + RCMP_W'(1);
    assign cur_attr = {cfg.back_color, cfg.fg_color};

    always_comb
    begin
        put_col    = cur_col_reg;
        put_row    = cur_row_reg;
        go_nl      = 1'b0;
        put_scroll = 1'b0;
        st_en      = 1'b0;
        st_col     = cur_col_reg;
        st_char    = char_byte;
        case (char_byte)
            CH_NL:
            begin
                go_nl = 1'b1;
            end
            CH_CR:
            begin
                put_col = '0;
            end
            CH_TAB:
            begin
                if (tab_col >= eff_cols)
                begin
                    go_nl = 1'b1;
                end
                else
                begin
                    put_col = tab_col[CW-1:0];
                end
            end
            CH_BS:
            begin
                if (cur_col_reg != '0)
                begin
                    put_col = cur_col_reg - CW'(1);
                    st_en   = 1'b1;
                    st_col  = put_col;
                    st_char = CH_SPACE;
                end
            end
            default:
            begin
                st_en = 1'b1;
                if (inc_col >= eff_cols)
                begin
                    go_nl = 1'b1;
                end
                else
                begin
                    put_col = inc_col[CW-1:0];
                end
            end
        endcase
        // New line, scrolling past the last row in use
        if (go_nl)
        begin
            put_col = '0;
            if (row_inc >= eff_rows)
            begin
                put_scroll = 1'b1;
                put_row    = RW'(eff_rows - RCMP_W'(1));
            end
            else
            begin
                put_row = row_inc[RW-1:0];
            end
        end
    end

    assign st_addr = AW'(cur_row_reg) * ROW_STRIDE + AW'(st_col);

    // Read request decode
    logic          rd_in_range;
    logic [AW-1:0] rd_req_addr;

    assign rd_in_range = (int'(read_row) < MAX_ROWS) && (int'(read_col) < MAX_COLS);
    assign rd_req_addr = AW'(read_row) * ROW_STRIDE + AW'(read_col);

    assign in_ready = (state_reg == ST_IDLE);

    // Sequencer and cell store port control
    always_comb
    begin
        state_next   = state_reg;
        scan_next    = scan_reg;
        wr_pend_next = 1'b0;
        wr_addr_next = wr_addr_reg;
        cur_col_next = cur_col_reg;
        cur_row_next = cur_row_reg;
        rd_ok_next   = rd_ok_reg;
        stage_next   = stage_reg;
        out_load     = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = scan_reg;
        mem_wdata    = '{ch: CH_SPACE, attr: ATTR_CLEAR};
        mem_re       = 1'b0;
        mem_raddr    = rd_req_addr;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    stage_next = '0;
                    scan_next  = '0;
                    case (cmd)
                        CMD_PUT:
                        begin
                            mem_we       = st_en;
                            mem_waddr    = st_addr;
                            mem_wdata    = '{ch: st_char, attr: cur_attr};
                            cur_col_next = put_col;
                            cur_row_next = put_row;
                            stage_next.cell_written = st_en;
                            if (st_en)
                            begin
                                stage_next.written_row  = OUT_ROW_W'(cur_row_reg);
                                stage_next.written_col  = OUT_COL_W'(st_col);
                                stage_next.written_char = st_char;
                                stage_next.written_attr = cur_attr;
                            end
                            stage_next.did_scroll = put_scroll;
                            state_next = put_scroll ? ST_SCROLL : ST_EMIT;
                        end
                        CMD_CLEAR:
                        begin
                            cur_col_next = '0;
                            cur_row_next = '0;
                            state_next   = ST_CLEAR;
                        end
                        CMD_READ:
                        begin
                            mem_re     = rd_in_range;
                            rd_ok_next = rd_in_range;
                            state_next = ST_RD;
                        end
                        default:
                        begin
                            state_next = ST_EMIT;
                        end
                    endcase
                    stage_next.cursor_col = OUT_COL_W'(cur_col_next);
                    stage_next.cursor_row = OUT_ROW_W'(cur_row_next);
                end
            end
            ST_RD:
            begin
                if (rd_ok_reg)
                begin
                    stage_next.cell_char = mem_rdata.ch;
                    stage_next.cell_attr = mem_rdata.attr;
                end
                state_next = ST_EMIT;
            end
            // Move each row up: read one row below, write it in the next cycle
            ST_SCROLL:
            begin
                mem_re       = 1'b1;
                mem_raddr    = scan_reg + ROW_STRIDE;
                mem_we       = wr_pend_reg;
                mem_waddr    = wr_addr_reg;
                mem_wdata    = mem_rdata;
                wr_pend_next = 1'b1;
                wr_addr_next = scan_reg;
                if (scan_reg == SCROLL_LAST)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    scan_next = scan_reg + AW'(1);
                end
            end
            ST_DRAIN:
            begin
                mem_we     = 1'b1;
                mem_waddr  = wr_addr_reg;
                mem_wdata  = mem_rdata;
                scan_next  = FILL_FIRST;
                state_next = ST_FILL;
            end
            // Blank the bottom stored row
            ST_FILL:
            begin
                mem_we    = 1'b1;
                mem_wdata = '{ch: CH_SPACE, attr: ATTR_SCROLL_FILL};
                if (scan_reg == CELL_LAST)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    scan_next = scan_reg + AW'(1);
                end
            end
            ST_INIT, ST_CLEAR:
            begin
                mem_we = 1'b1;
                if (scan_reg == CELL_LAST)
                begin
                    state_next = (state_reg == ST_INIT) ? ST_IDLE : ST_EMIT;
                end
                else
                begin
                    scan_next = scan_reg + AW'(1);
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result register
    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            scan_reg      <= '0;
            wr_pend_reg   <= 1'b0;
            cur_col_reg   <= '0;
            cur_row_reg   <= '0;
            rd_ok_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_reg      <= scan_next;
            wr_pend_reg   <= wr_pend_next;
            cur_col_reg   <= cur_col_next;
            cur_row_reg   <= cur_row_next;
            rd_ok_reg     <= rd_ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        wr_addr_reg <= wr_addr_next;
        stage_reg   <= stage_next;
        if (out_load)
        begin
            out_reg <= stage_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

/* hw/rtl/text_console_cursor_engine.sv */
// ----------------------------------------------------------------------------
// text_console_cursor_engine
// Text console: character/attribute grid in a cell store plus a cursor.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one command per transfer: put a
//   byte, clear the screen, or read one cell. Every command gives exactly one
//   transfer on the output channel (out_valid/out_ready).
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
//   ready; write it only while no command is in flight.
// Command flow from accept to the result register, with that register free:
//   a put without scroll or an unused command goes straight to the result;
//   a read first passes the read state; a clear first walks every cell; a
//   put that scrolls moves each row up, then blanks the bottom stored row.
// Throughput: one command at a time; the next is taken the cycle after the
//   result is loaded. Scroll and clear walk every cell through the single
//   write port of the cell store, one cell per cycle.
// Reset: cursor homes, configuration returns to defaults, and a clearing pass
//   over all MAX_ROWS*MAX_COLS cells fills the grid; in_ready stays low meanwhile.
// Stall: a result waits in the output register while the next command is
//   accepted and worked on; it completes once that register is free.
// ----------------------------------------------------------------------------
module text_console_cursor_engine
    import txcon_pkg::*;
#(
    parameter int MAX_ROWS = MAX_ROWS_DEF,
    parameter int MAX_COLS = MAX_COLS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [CMD_W-1:0]      cmd,
    input  logic [CHAR_W-1:0]     char_byte,
    input  logic [4:0]            read_row,
    input  logic [6:0]            read_col,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  cell_written,
    output logic [OUT_ROW_W-1:0]  written_row,
    output logic [OUT_COL_W-1:0]  written_col,
    output logic [CHAR_W-1:0]     written_char,
    output logic [ATTR_W-1:0]     written_attr,
    output logic                  did_scroll,
    output logic [OUT_COL_W-1:0]  cursor_col_out,
    output logic [OUT_ROW_W-1:0]  cursor_row_out,
    output logic [CHAR_W-1:0]     cell_char,
    output logic [ATTR_W-1:0]     cell_attr
);

    localparam int AW = $clog2(MAX_ROWS * MAX_COLS);

    txcon_cfg_t    cfg_reg;
    txcon_result_t res;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    txcon_cell_t   mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    txcon_cell_t   mem_rdata;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fg_color    <= FG_RESET;
            cfg_reg.back_color  <= BG_RESET;
            cfg_reg.cols_in_use <= COLS_RESET;
            cfg_reg.rows_in_use <= ROWS_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_FG_COLOR: cfg_reg.fg_color    <= cfg_data[COLOR_W-1:0];
                CFG_BG_COLOR: cfg_reg.back_color  <= cfg_data[COLOR_W-1:0];
                CFG_COLS:     cfg_reg.cols_in_use <= cfg_data[COLS_CFG_W-1:0];
                CFG_ROWS:     cfg_reg.rows_in_use <= cfg_data[ROWS_CFG_W-1:0];
                default:      cfg_reg             <= cfg_reg;
            endcase
        end
    end

    txcon_seq #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .char_byte (char_byte),
        .read_row  (read_row),
        .read_col  (read_col),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    txcon_grid_mem #(
        .DEPTH (MAX_ROWS * MAX_COLS)
    ) u_grid (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Result fields
    assign cell_written   = res.cell_written;
    assign written_row    = res.written_row;
    assign written_col    = res.written_col;
    assign written_char   = res.written_char;
    assign written_attr   = res.written_attr;
    assign did_scroll     = res.did_scroll;
    assign cursor_col_out = res.cursor_col;
    assign cursor_row_out = res.cursor_row;
    assign cell_char      = res.cell_char;
    assign cell_attr      = res.cell_attr;

endmodule

/* hw/rtl/txcon_checker.sv */
// ----------------------------------------------------------------------------
// txcon_checker
// Port-level checks of the text console, bound to the top level.
// ----------------------------------------------------------------------------
module txcon_checker
    import txcon_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic                  cell_written,
    input logic [OUT_ROW_W-1:0]  written_row,
    input logic [OUT_COL_W-1:0]  written_col,
    input logic [CHAR_W-1:0]     written_char,
    input logic [ATTR_W-1:0]     written_attr,
    input logic                  did_scroll,
    input logic [OUT_COL_W-1:0]  cursor_col_out,
    input logic [OUT_ROW_W-1:0]  cursor_row_out,
    input logic [CHAR_W-1:0]     cell_char,
    input logic [ATTR_W-1:0]     cell_attr
);

    // One command at a time: input closes right after a transfer
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input still open after a transfer");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cursor_col_out)
            && $stable(cursor_row_out) && $stable(cell_written))
        else $error("result changed while stalled");

    // A scroll always ends on column zero
    a_scroll_col: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && did_scroll |-> cursor_col_out == '0)
        else $error("scroll with cursor off column zero");

    // A stored cell never comes with read data
    a_write_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && cell_written |-> cell_char == '0 && cell_attr == '0)
        else $error("store result carries read data");

    // Without a store the write fields are zero
    a_write_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !cell_written |-> written_row == '0 && written_col == '0
            && written_char == '0 && written_attr == '0)
        else $error("write fields set without a store");

endmodule

bind text_console_cursor_engine txcon_checker u_txcon_checker (.*);
